@@ hw/rtl/itoa_pkg.sv @@
// Shared types, constants and a helper function for the integer to ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TYPE_BITS  = 2;
  localparam int CHAR_BITS  = 8;
  localparam int DIGIT_BITS = 4;

  // Format codes on req_type; the unused code converts as unsigned decimal
  localparam logic [TYPE_BITS-1:0] FMT_SIGNED   = 2'd0;
  localparam logic [TYPE_BITS-1:0] FMT_UNSIGNED = 2'd1;
  localparam logic [TYPE_BITS-1:0] FMT_HEX      = 2'd2;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;

  // Cell operations
  localparam logic [1:0] CELL_HOLD      = 2'd0;
  localparam logic [1:0] CELL_CLEAR     = 2'd1;
  localparam logic [1:0] CELL_SHIFT_BIT = 2'd2;
  localparam logic [1:0] CELL_SHIFT_DIG = 2'd3;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dabble;
  } cell_ctrl_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input digit_t d);
    logic [CHAR_BITS-1:0] d_ext;
    d_ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_A + d_ext - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itoa_if.sv @@
// Valid/ready channel interfaces for the input words and the output characters.
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [itoa_pkg::VALUE_BITS-1:0]       value;
  logic [itoa_pkg::TYPE_BITS-1:0]        req_type;

  modport source (output valid, output value, output req_type, input ready);
  modport sink   (input valid, input value, input req_type, output ready);
endinterface

interface itoa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [itoa_pkg::CHAR_BITS-1:0]        char_code;
  logic                                  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/integer_to_ascii_digits_unit.sv @@
// Top level of the integer to ASCII converter: control sequencer, digit row and output register.
`timescale 1ns / 1ps
`default_nettype none

// Converts one word per input beat to its text in signed decimal, unsigned decimal or
// lower-case hex, one output beat per character, most significant first, no leading
// zeros, last set on the final character. The word shifts into a row of digit cells one
// bit per cycle (shift-and-add-3 for decimal), then the row shifts up one digit per cycle,
// dropping leading zeros and, while the output accepts, emitting the rest, plus one beat
// for a leading '-'. The next word is taken as soon as the last character sits in the
// output register; no new word is accepted while one is still being converted or emitted.
module integer_to_ascii_digits_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  itoa_in_if.sink   in_ch,
  itoa_out_if.source out_ch
);

  localparam int DEC_CELLS = (WORD_BITS * 30103) / 100000 + 1;
  localparam int HEX_CELLS = (WORD_BITS + 3) / 4;
  localparam int NCELLS    = (DEC_CELLS > HEX_CELLS) ? DEC_CELLS : HEX_CELLS;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int REM_W     = $clog2(NCELLS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           state, state_next;
  logic [CNT_W-1:0]     bit_cnt, bit_cnt_next;
  logic [REM_W-1:0]     rem_cnt, rem_cnt_next;
  logic [WORD_BITS-1:0] shreg, shreg_next;
  logic                 neg, neg_next;
  logic                 dabble, dabble_next;

  logic                 out_valid, out_valid_next;
  logic [itoa_pkg::CHAR_BITS-1:0] out_char;
  logic                 out_last;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mag;
  logic                 word_neg;
  logic                 in_take;
  logic                 out_load;

  itoa_pkg::cell_ctrl_t ctrl;
  itoa_pkg::digit_t     top_digit;
  logic                 spill;

  assign word     = WORD_BITS'(in_ch.value);
  assign word_neg = (in_ch.req_type == itoa_pkg::FMT_SIGNED) && word[WORD_BITS-1];
  assign mag      = word_neg ? (~word + {{(WORD_BITS-1){1'b0}}, 1'b1}) : word;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state == ST_EMIT) && (!out_valid || out_ch.ready);

  itoa_chain #(
    .NCELLS (NCELLS)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (shreg[WORD_BITS-1]),
    .top_digit (top_digit),
    .spill     (spill)
  );

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    rem_cnt_next = rem_cnt;
    shreg_next   = shreg;
    neg_next     = neg;
    dabble_next  = dabble;
    ctrl.op      = itoa_pkg::CELL_HOLD;
    ctrl.dabble  = dabble;

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          ctrl.op      = itoa_pkg::CELL_CLEAR;
          shreg_next   = mag;
          bit_cnt_next = CNT_W'(WORD_BITS);
          neg_next     = word_neg;
          dabble_next  = (in_ch.req_type != itoa_pkg::FMT_HEX);
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.op      = itoa_pkg::CELL_SHIFT_BIT;
        shreg_next   = {shreg[WORD_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt - CNT_W'(1);
        if (bit_cnt == CNT_W'(1)) begin
          rem_cnt_next = REM_W'(NCELLS);
          state_next   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the units digit
        if ((top_digit == '0) && (rem_cnt > REM_W'(1))) begin
          ctrl.op      = itoa_pkg::CELL_SHIFT_DIG;
          rem_cnt_next = rem_cnt - REM_W'(1);
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (neg) begin
            neg_next = 1'b0;
          end else begin
            ctrl.op      = itoa_pkg::CELL_SHIFT_DIG;
            rem_cnt_next = rem_cnt - REM_W'(1);
            if (rem_cnt == REM_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt <= bit_cnt_next;
    rem_cnt <= rem_cnt_next;
    shreg   <= shreg_next;
    neg     <= neg_next;
    dabble  <= dabble_next;
    if (out_load) begin
      out_char <= neg ? itoa_pkg::CHAR_MINUS : itoa_pkg::digit_char(top_digit);
      out_last <= !neg && (rem_cnt == REM_W'(1));
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_char;
  assign out_ch.last      = out_last;

  // Characters are only loaded from the emit phase
  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_EMIT)
    else $error("output beat raised outside emit phase");

  // Every accepted word starts a full-length conversion
  a_conv_start: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_CONV) && (bit_cnt == CNT_W'(WORD_BITS)))
    else $error("conversion did not start after input beat");

  // The digit row is wide enough: nothing falls off the top while shifting in
  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !spill)
    else $error("digit row overflowed");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.char_code == itoa_pkg::CHAR_MINUS)) |-> !out_ch.last)
    else $error("minus sign marked as last");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem_cnt != '0))
    else $error("emit phase with no digits left");

endmodule

`default_nettype wire

@@ hw/rtl/itoa_cell.sv @@
// One digit cell: shift-and-add-3 step for decimal, plain nibble shift for hex.
`timescale 1ns / 1ps
`default_nettype none

module itoa_cell (
  input  wire logic                 clk,
  input  wire itoa_pkg::cell_ctrl_t ctrl,
  input  wire logic                 bit_in,
  input  wire itoa_pkg::digit_t     digit_in,
  output itoa_pkg::digit_t          digit,
  output logic                      carry_out
);

  itoa_pkg::digit_t adj;
  itoa_pkg::digit_t digit_next;

  // Add 3 before the shift so the digit stays BCD after doubling
  assign adj       = (ctrl.dabble && (digit >= 4'd5)) ? digit + 4'd3 : digit;
  assign carry_out = adj[3];

  always_comb begin
    unique case (ctrl.op)
      itoa_pkg::CELL_CLEAR:     digit_next = '0;
      itoa_pkg::CELL_SHIFT_BIT: digit_next = {adj[2:0], bit_in};
      itoa_pkg::CELL_SHIFT_DIG: digit_next = digit_in;
      default:                  digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/itoa_chain.sv @@
// Row of digit cells, least significant cell first, with the top digit brought out.
`timescale 1ns / 1ps
`default_nettype none

module itoa_chain #(
  parameter int NCELLS = 10
) (
  input  wire logic                 clk,
  input  wire itoa_pkg::cell_ctrl_t ctrl,
  input  wire logic                 bit_in,
  output itoa_pkg::digit_t          top_digit,
  output logic                      spill
);

  itoa_pkg::digit_t digits [NCELLS];
  logic             carry  [NCELLS+1];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    itoa_pkg::digit_t dig_in;
    if (i == 0) begin : g_first
      assign dig_in = '0;
    end else begin : g_rest
      assign dig_in = digits[i-1];
    end

    itoa_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (carry[i]),
      .digit_in  (dig_in),
      .digit     (digits[i]),
      .carry_out (carry[i+1])
    );
  end

  assign top_digit = digits[NCELLS-1];
  // Carry out of the top cell; never set while shifting in when the row is wide enough
  assign spill     = carry[NCELLS];

endmodule

`default_nettype wire

@@ tb/tb_integer_to_ascii_digits_unit.sv @@
// Testbench for the integer to ASCII converter: random and directed words, per-character checks.
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits_unit;

  localparam int WORD_BITS = 32;
  localparam logic [itoa_pkg::TYPE_BITS-1:0] FMT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [WORD_BITS-1:0]           value;
    logic [itoa_pkg::TYPE_BITS-1:0] req_type;
  } word_req_t;

  typedef struct packed {
    logic [itoa_pkg::CHAR_BITS-1:0] char_code;
    logic                           last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  word_req_t  pending_words[$];
  text_beat_t expected_text[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          sender_paused  = 1'b0;
  int unsigned error_count    = 0;

  integer_to_ascii_digits_unit #(.WORD_BITS(WORD_BITS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Text of one word, most significant character first
  function automatic void queue_text(input logic [WORD_BITS-1:0] word,
                                     input logic [itoa_pkg::TYPE_BITS-1:0] fmt);
    logic [WORD_BITS-1:0]           mag;
    logic [WORD_BITS-1:0]           radix;
    logic [WORD_BITS-1:0]           rem;
    logic [itoa_pkg::CHAR_BITS-1:0] digs[$];
    text_beat_t                     beat;
    mag = word;
    radix = 10;
    if (fmt == itoa_pkg::FMT_SIGNED && word[WORD_BITS-1]) begin
      beat.char_code = itoa_pkg::CHAR_MINUS;
      beat.last = 1'b0;
      expected_text.push_back(beat);
      mag = -word;
    end else if (fmt == itoa_pkg::FMT_HEX) begin
      radix = 16;
    end
    do begin
      rem = mag % radix;
      if (rem < 10) begin
        digs.push_front(itoa_pkg::CHAR_ZERO + rem[itoa_pkg::CHAR_BITS-1:0]);
      end else begin
        digs.push_front(itoa_pkg::CHAR_A + rem[itoa_pkg::CHAR_BITS-1:0] - 8'd10);
      end
      mag = mag / radix;
    end while (mag != 0);
    for (int i = 0; i < digs.size(); i++) begin
      beat.char_code = digs[i];
      beat.last = (i == digs.size() - 1);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : drive_words
    word_req_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        queue_text(in_ch.value, in_ch.req_type);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat until it is taken
      end else if (!sender_paused && pending_words.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.value    <= nxt.value;
        in_ch.req_type <= nxt.req_type;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_chars
    text_beat_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected char_code %h last %b", out_ch.char_code, out_ch.last);
          error_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected %h, got %h", want.char_code, out_ch.char_code);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_ch.last);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_word(input logic [WORD_BITS-1:0] value,
                          input logic [itoa_pkg::TYPE_BITS-1:0] fmt);
    word_req_t w;
    w.value = value;
    w.req_type = fmt;
    pending_words.push_back(w);
  endtask

  task automatic add_random_words(input int n);
    logic [WORD_BITS-1:0]           v;
    logic [itoa_pkg::TYPE_BITS-1:0] f;
    int unsigned                    pick;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(WORD_BITS - 1);
        2: v = $urandom_range(99);
        default: v = -$urandom_range(1000);
      endcase
      pick = $urandom_range(9);
      if (pick < 3) begin
        f = itoa_pkg::FMT_SIGNED;
      end else if (pick < 6) begin
        f = itoa_pkg::FMT_UNSIGNED;
      end else if (pick < 9) begin
        f = itoa_pkg::FMT_HEX;
      end else begin
        f = FMT_UNUSED;
      end
      add_word(v, f);
    end
  endtask

  task automatic wait_words_taken();
    while (pending_words.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  task automatic wait_text_drained();
    while (expected_text.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.req_type = itoa_pkg::FMT_SIGNED;
    out_ch.ready   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero, extremes and radix boundaries
    add_word(32'd0, itoa_pkg::FMT_SIGNED);
    add_word(32'd0, itoa_pkg::FMT_UNSIGNED);
    add_word(32'd0, itoa_pkg::FMT_HEX);
    add_word(32'h8000_0000, itoa_pkg::FMT_SIGNED);
    add_word(32'h8000_0000, itoa_pkg::FMT_UNSIGNED);
    add_word(32'h8000_0000, itoa_pkg::FMT_HEX);
    add_word(32'hffff_ffff, itoa_pkg::FMT_SIGNED);
    add_word(32'hffff_ffff, itoa_pkg::FMT_UNSIGNED);
    add_word(32'hffff_ffff, itoa_pkg::FMT_HEX);
    add_word(32'h7fff_ffff, itoa_pkg::FMT_SIGNED);
    add_word(32'h7fff_ffff, itoa_pkg::FMT_UNSIGNED);
    add_word(32'h7fff_ffff, itoa_pkg::FMT_HEX);
    add_word(32'd1, itoa_pkg::FMT_SIGNED);
    add_word(32'd9, itoa_pkg::FMT_UNSIGNED);
    add_word(32'd10, itoa_pkg::FMT_UNSIGNED);
    add_word(32'd15, itoa_pkg::FMT_HEX);
    add_word(32'd16, itoa_pkg::FMT_HEX);
    add_word(32'hdead_beef, itoa_pkg::FMT_HEX);
    add_word(32'd1000000000, itoa_pkg::FMT_UNSIGNED);
    add_word(32'hffff_ffff, FMT_UNUSED);
    add_word(32'd12345, FMT_UNUSED);
    add_word(32'h8000_0000, FMT_UNUSED);
    wait_words_taken();

    // hold the sender back with words queued until the text has drained
    sender_paused = 1'b1;
    add_random_words(50);
    wait_text_drained();
    sender_paused = 1'b0;
    wait_words_taken();

    send_idle_pct = 84;
    add_random_words(50);
    wait_words_taken();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    add_random_words(50);
    wait_words_taken();

    send_idle_pct  = 8;
    recv_stall_pct = 8;
    add_random_words(50);
    wait_words_taken();

    wait_text_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
